FILE: design/clsbr_pkg.sv
// Shared types, codes and constants of the character LCD shadow buffer refresh unit.
package clsbr_pkg;

    localparam int DEF_ROWS = 2;
    localparam int DEF_COLS = 16;

    localparam int PCW = 5;

    localparam logic [2:0] REQ_PLACE   = 3'd0;
    localparam logic [2:0] REQ_APPEND  = 3'd1;
    localparam logic [2:0] REQ_NUMBER  = 3'd2;
    localparam logic [2:0] REQ_TWO     = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;
    localparam logic [2:0] REQ_REFRESH = 3'd5;
    localparam logic [2:0] REQ_INIT    = 3'd6;

    // Program entry points in the microcode table.
    localparam logic [PCW-1:0] ENT_CLEAR   = 5'd0;
    localparam logic [PCW-1:0] ENT_PLACE   = 5'd1;
    localparam logic [PCW-1:0] ENT_APPEND  = 5'd2;
    localparam logic [PCW-1:0] ENT_NUMBER  = 5'd4;
    localparam logic [PCW-1:0] ENT_TWO     = 5'd14;
    localparam logic [PCW-1:0] ENT_REFRESH = 5'd19;
    localparam logic [PCW-1:0] ENT_INIT    = 5'd23;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
    localparam logic [7:0] CMD_WAKE      = 8'h30;
    localparam logic [7:0] CMD_FOUR_BIT  = 8'h20;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;

    localparam logic [13:0] MAG_MAX = 14'd9999;
    localparam logic [6:0]  TWO_MAX = 7'd99;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_STORE,
        OP_SETPOS,
        OP_PUT,
        OP_LOADNUM,
        OP_LOADTWO,
        OP_EXTRACT,
        OP_REFSTART,
        OP_ROWCMD,
        OP_ROWDATA,
        OP_ROWNEXT,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_GE,
        C_POS,
        C_MORE_COLS,
        C_MORE_ROWS
    } cond_t;

    typedef enum logic [1:0] {
        SRC_CHAR,
        SRC_MINUS,
        SRC_DIGIT,
        SRC_UNIT
    } src_t;

    typedef struct packed {
        op_t             op;
        src_t            src;
        logic [1:0]      arg;
        cond_t           cond;
        logic [PCW-1:0]  target;
        logic            fin;
        logic [7:0]      val;
        logic            nib;
        logic            lst;
    } cw_t;

    typedef struct packed {
        logic ge;
        logic pos;
        logic more_cols;
        logic more_rows;
        logic hold;
    } flags_t;

    // Weight of the decimal digit selected by idx (1 tens, 2 hundreds, 3 thousands).
    function automatic logic [13:0] pow10(input logic [1:0] idx);
        logic [13:0] p;
        unique case (idx)
            2'd3:    p = 14'd1000;
            2'd2:    p = 14'd100;
            2'd1:    p = 14'd10;
            default: p = 14'd1;
        endcase
        return p;
    endfunction

    // Set-address command for the start of row r.
    function automatic logic [7:0] row_cmd(input logic [1:0] r, input logic [7:0] cols);
        logic [7:0] off;
        unique case (r)
            2'd0:    off = 8'h00;
            2'd1:    off = 8'h40;
            2'd2:    off = cols;
            default: off = 8'h40 + cols;
        endcase
        return CMD_SET_ADDR | off;
    endfunction

endpackage

FILE: design/clsbr_ucode_rom.sv
// Microcode table: one control word per program step.
module clsbr_ucode_rom (
    input  logic [clsbr_pkg::PCW-1:0] pc,
    output clsbr_pkg::cw_t            cw
);
    import clsbr_pkg::*;

    function automatic cw_t mk(input op_t op, input src_t src, input logic [1:0] arg,
                               input cond_t cond, input logic [PCW-1:0] target,
                               input logic fin, input logic [7:0] val,
                               input logic nib, input logic lst);
        cw_t w;
        w.op     = op;
        w.src    = src;
        w.arg    = arg;
        w.cond   = cond;
        w.target = target;
        w.fin    = fin;
        w.val    = val;
        w.nib    = nib;
        w.lst    = lst;
        return w;
    endfunction

    always_comb
    begin
        unique case (pc)
            // Clear and place are single steps.
            5'd0:  cw = mk(OP_CLEAR,   SRC_CHAR,  2'd0, C_NONE, 5'd0,  1'b1, 8'h00, 1'b0, 1'b0);
            5'd1:  cw = mk(OP_STORE,   SRC_CHAR,  2'd0, C_NONE, 5'd0,  1'b1, 8'h00, 1'b0, 1'b0);
            // Append: optional position, then store and advance.
            5'd2:  cw = mk(OP_SETPOS,  SRC_CHAR,  2'd1, C_NONE, 5'd0,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd3:  cw = mk(OP_PUT,     SRC_CHAR,  2'd0, C_NONE, 5'd0,  1'b1, 8'h00, 1'b0, 1'b0);
            // Number: the minus sign is skipped for non-negative values.
            5'd4:  cw = mk(OP_SETPOS,  SRC_CHAR,  2'd0, C_NONE, 5'd0,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd5:  cw = mk(OP_LOADNUM, SRC_CHAR,  2'd0, C_POS,  5'd7,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd6:  cw = mk(OP_PUT,     SRC_MINUS, 2'd0, C_NONE, 5'd0,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd7:  cw = mk(OP_EXTRACT, SRC_CHAR,  2'd3, C_GE,   5'd7,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd8:  cw = mk(OP_EXTRACT, SRC_CHAR,  2'd2, C_GE,   5'd8,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd9:  cw = mk(OP_EXTRACT, SRC_CHAR,  2'd1, C_GE,   5'd9,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd10: cw = mk(OP_PUT,     SRC_DIGIT, 2'd3, C_NONE, 5'd0,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd11: cw = mk(OP_PUT,     SRC_DIGIT, 2'd2, C_NONE, 5'd0,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd12: cw = mk(OP_PUT,     SRC_DIGIT, 2'd1, C_NONE, 5'd0,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd13: cw = mk(OP_PUT,     SRC_UNIT,  2'd0, C_NONE, 5'd0,  1'b1, 8'h00, 1'b0, 1'b0);
            // Two-digit value.
            5'd14: cw = mk(OP_SETPOS,  SRC_CHAR,  2'd0, C_NONE, 5'd0,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd15: cw = mk(OP_LOADTWO, SRC_CHAR,  2'd0, C_NONE, 5'd0,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd16: cw = mk(OP_EXTRACT, SRC_CHAR,  2'd1, C_GE,   5'd16, 1'b0, 8'h00, 1'b0, 1'b0);
            5'd17: cw = mk(OP_PUT,     SRC_DIGIT, 2'd1, C_NONE, 5'd0,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd18: cw = mk(OP_PUT,     SRC_UNIT,  2'd0, C_NONE, 5'd0,  1'b1, 8'h00, 1'b0, 1'b0);
            // Refresh: per row one address command and the row's bytes.
            5'd19: cw = mk(OP_REFSTART, SRC_CHAR, 2'd0, C_NONE, 5'd0,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd20: cw = mk(OP_ROWCMD,  SRC_CHAR,  2'd0, C_NONE, 5'd0,  1'b0, 8'h00, 1'b0, 1'b0);
            5'd21: cw = mk(OP_ROWDATA, SRC_CHAR,  2'd0, C_MORE_COLS, 5'd21, 1'b0, 8'h00,
                           1'b0, 1'b0);
            5'd22: cw = mk(OP_ROWNEXT, SRC_CHAR,  2'd0, C_MORE_ROWS, 5'd20, 1'b1, 8'h00,
                           1'b0, 1'b0);
            // Init: wake-up nibbles and the four-bit switch, then function set and display on.
            5'd23: cw = mk(OP_EMIT, SRC_CHAR, 2'd0, C_NONE, 5'd0, 1'b0, CMD_WAKE,     1'b1, 1'b0);
            5'd24: cw = mk(OP_EMIT, SRC_CHAR, 2'd0, C_NONE, 5'd0, 1'b0, CMD_WAKE,     1'b1, 1'b0);
            5'd25: cw = mk(OP_EMIT, SRC_CHAR, 2'd0, C_NONE, 5'd0, 1'b0, CMD_WAKE,     1'b1, 1'b0);
            5'd26: cw = mk(OP_EMIT, SRC_CHAR, 2'd0, C_NONE, 5'd0, 1'b0, CMD_FOUR_BIT, 1'b1, 1'b0);
            5'd27: cw = mk(OP_EMIT, SRC_CHAR, 2'd0, C_NONE, 5'd0, 1'b0, CMD_FUNC_SET, 1'b0, 1'b0);
            5'd28: cw = mk(OP_EMIT, SRC_CHAR, 2'd0, C_NONE, 5'd0, 1'b1, CMD_DISP_ON,  1'b0, 1'b1);
            default: cw = mk(OP_NOP, SRC_CHAR, 2'd0, C_NONE, 5'd0, 1'b1, 8'h00, 1'b0, 1'b0);
        endcase
    end

endmodule

FILE: design/clsbr_sequencer.sv
// Step counter with conditional jumps that walks the microcode programs.
module clsbr_sequencer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [2:0]                req_type,
    input  clsbr_pkg::cw_t            cw,
    input  clsbr_pkg::flags_t         flags,
    output logic [clsbr_pkg::PCW-1:0] pc,
    output logic                      busy,
    output logic                      step
);
    import clsbr_pkg::*;

    logic [PCW-1:0] pc_reg;
    logic           busy_reg;
    logic           jump;
    logic [PCW-1:0] entry;
    logic           entry_ok;

    assign pc   = pc_reg;
    assign busy = busy_reg;
    assign step = busy_reg && !flags.hold;

    always_comb
    begin
        unique case (cw.cond)
            C_NONE:      jump = 1'b0;
            C_GE:        jump = flags.ge;
            C_POS:       jump = flags.pos;
            C_MORE_COLS: jump = flags.more_cols;
            C_MORE_ROWS: jump = flags.more_rows;
            default:     jump = 1'b0;
        endcase
    end

    always_comb
    begin
        entry_ok = 1'b1;
        unique case (req_type)
            REQ_PLACE:   entry = ENT_PLACE;
            REQ_APPEND:  entry = ENT_APPEND;
            REQ_NUMBER:  entry = ENT_NUMBER;
            REQ_TWO:     entry = ENT_TWO;
            REQ_CLEAR:   entry = ENT_CLEAR;
            REQ_REFRESH: entry = ENT_REFRESH;
            REQ_INIT:    entry = ENT_INIT;
            default:
            begin
                entry    = ENT_CLEAR;
                entry_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else if (accept)
        begin
            busy_reg <= entry_ok;
            pc_reg   <= entry;
        end
        else if (step)
        begin
            if (jump)
                pc_reg <= cw.target;
            else if (cw.fin)
                busy_reg <= 1'b0;
            else
                pc_reg <= pc_reg + 1'b1;
        end
    end

    a_refresh_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req_type == REQ_REFRESH |=> busy_reg && pc_reg == ENT_REFRESH)
        else $error("refresh request did not start its program");

endmodule

FILE: design/clsbr_datapath.sv
// Shadow screen memory, cursor, digit extraction and registered output stage.
module clsbr_datapath #(
    parameter int ROWS = clsbr_pkg::DEF_ROWS,
    parameter int COLS = clsbr_pkg::DEF_COLS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         row,
    input  logic [7:0]         col,
    input  logic               use_position,
    input  logic [7:0]         char_code,
    input  logic signed [31:0] number,
    input  logic [7:0]         two_digit,
    input  clsbr_pkg::cw_t     cw,
    input  logic               step,
    output clsbr_pkg::flags_t  flags,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               to_data,
    output logic [7:0]         value,
    output logic               nibble_only,
    output logic               last
);
    import clsbr_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int CCW   = $clog2(COLS);
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Captured request fields.
    logic [7:0]  row_reg;
    logic [7:0]  col_reg;
    logic        usepos_reg;
    logic [7:0]  char_reg;
    logic [31:0] num_reg;
    logic [7:0]  two_reg;

    logic [AW-1:0]  cursor_reg;
    logic [13:0]    mag_reg;
    logic [3:0]     dig_reg [4];
    logic           seen_reg;
    logic [AW-1:0]  addr_reg;
    logic [RW-1:0]  rcnt_reg;
    logic [CCW-1:0] ccnt_reg;

    logic [7:0]       mem [CELLS];
    logic [CELLS-1:0] vld_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_vld_reg;

    logic       out_valid_reg;
    logic       out_to_data_reg;
    logic [7:0] out_value_reg;
    logic       out_nib_reg;
    logic       out_last_reg;

    logic [RW-1:0]  row_tab [256];
    logic [CCW-1:0] col_tab [256];

    logic [AW-1:0]  pos_cell;
    logic [AW-1:0]  cursor_inc;
    logic [AW-1:0]  addr_inc;
    logic [AW-1:0]  rd_addr;
    logic [31:0]    num_abs;
    logic [13:0]    mag_sat;
    logic [6:0]     two_sat;
    logic [13:0]    pow;
    logic           ge;
    logic [3:0]     d_sel;
    logic [7:0]     wr_byte;
    logic [AW-1:0]  wr_addr;
    logic           wr_en;
    logic           emits;
    logic           emit_now;
    logic           more_cols;
    logic           more_rows;
    logic [7:0]     emit_value;

    for (genvar g = 0; g < 256; g++)
    begin : g_mod_tab
        assign row_tab[g] = RW'(g % ROWS);
        assign col_tab[g] = CCW'(g % COLS);
    end

    assign pos_cell   = AW'(32'(row_tab[row_reg]) * 32'(COLS) + 32'(col_tab[col_reg]));
    assign cursor_inc = (cursor_reg == AW'(CELLS - 1)) ? '0 : cursor_reg + 1'b1;
    assign addr_inc   = (addr_reg == AW'(CELLS - 1)) ? '0 : addr_reg + 1'b1;
    assign rd_addr    = (cw.op == OP_ROWDATA) ? addr_inc : addr_reg;

    assign num_abs = num_reg[31] ? (32'd0 - num_reg) : num_reg;
    assign mag_sat = (num_abs > 32'(MAG_MAX)) ? MAG_MAX : num_abs[13:0];
    assign two_sat = (two_reg > 8'(TWO_MAX)) ? TWO_MAX : two_reg[6:0];
    assign pow     = pow10(cw.arg);
    assign ge      = mag_reg >= pow;
    assign d_sel   = dig_reg[cw.arg];

    assign more_cols = ccnt_reg != CCW'(COLS - 1);
    assign more_rows = rcnt_reg != RW'(ROWS - 1);

    assign emits    = (cw.op == OP_ROWCMD) || (cw.op == OP_ROWDATA) || (cw.op == OP_EMIT);
    assign emit_now = step && emits;

    assign flags.ge        = ge;
    assign flags.pos       = !num_reg[31];
    assign flags.more_cols = more_cols;
    assign flags.more_rows = more_rows;
    assign flags.hold      = emits && out_valid_reg && out_stall;

    always_comb
    begin
        unique case (cw.src)
            SRC_CHAR:  wr_byte = char_reg;
            SRC_MINUS: wr_byte = CH_MINUS;
            SRC_DIGIT: wr_byte = (d_sel != 4'd0 || seen_reg) ? CH_ZERO + {4'd0, d_sel}
                                                             : CH_SPACE;
            SRC_UNIT:  wr_byte = CH_ZERO + {4'd0, mag_reg[3:0]};
            default:   wr_byte = char_reg;
        endcase
        wr_en   = step && ((cw.op == OP_PUT) || (cw.op == OP_STORE));
        wr_addr = (cw.op == OP_STORE) ? pos_cell : cursor_reg;
    end

    always_comb
    begin
        priority if (cw.op == OP_ROWCMD)
            emit_value = row_cmd(2'(rcnt_reg), 8'(COLS));
        else if (cw.op == OP_ROWDATA)
            emit_value = rd_vld_reg ? rd_data_reg : CH_SPACE;
        else
            emit_value = cw.val;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            addr_reg      <= '0;
            rcnt_reg      <= '0;
            ccnt_reg      <= '0;
        end
        else
        begin
            if (emit_now)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;

            if (step)
            begin
                unique case (cw.op)
                    OP_CLEAR:    vld_reg <= '0;
                    OP_STORE:    cursor_reg <= pos_cell;
                    OP_SETPOS:
                    begin
                        if (!cw.arg[0] || usepos_reg)
                            cursor_reg <= pos_cell;
                    end
                    OP_PUT:      cursor_reg <= cursor_inc;
                    OP_REFSTART:
                    begin
                        addr_reg <= '0;
                        rcnt_reg <= '0;
                        ccnt_reg <= '0;
                    end
                    OP_ROWDATA:
                    begin
                        addr_reg <= addr_inc;
                        ccnt_reg <= more_cols ? ccnt_reg + 1'b1 : '0;
                    end
                    OP_ROWNEXT:
                    begin
                        if (more_rows)
                            rcnt_reg <= rcnt_reg + 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg    <= row;
            col_reg    <= col;
            usepos_reg <= use_position;
            char_reg   <= char_code;
            num_reg    <= number;
            two_reg    <= two_digit;
        end
        if (step)
        begin
            unique case (cw.op)
                OP_LOADNUM:
                begin
                    mag_reg  <= mag_sat;
                    dig_reg  <= '{default: 4'd0};
                    seen_reg <= 1'b0;
                end
                OP_LOADTWO:
                begin
                    mag_reg  <= {7'd0, two_sat};
                    dig_reg  <= '{default: 4'd0};
                    seen_reg <= 1'b1;
                end
                OP_EXTRACT:
                begin
                    if (ge)
                    begin
                        mag_reg          <= mag_reg - pow;
                        dig_reg[cw.arg]  <= d_sel + 1'b1;
                    end
                end
                OP_PUT:
                begin
                    if (cw.src == SRC_DIGIT && d_sel != 4'd0)
                        seen_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (emit_now)
        begin
            out_to_data_reg <= (cw.op == OP_ROWDATA);
            out_value_reg   <= emit_value;
            out_nib_reg     <= (cw.op == OP_EMIT) && cw.nib;
            out_last_reg    <= cw.lst || ((cw.op == OP_ROWDATA) && !more_cols && !more_rows);
        end
    end

    // Screen memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_byte;
        if (step)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign to_data     = out_to_data_reg;
    assign value       = out_value_reg;
    assign nibble_only = out_nib_reg;
    assign last        = out_last_reg;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        emit_now |-> !(out_valid_reg && out_stall))
        else $error("write issued while the output item is still stalled");

    a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
        step && cw.op == OP_ROWCMD |-> 32'(addr_reg) == 32'(rcnt_reg) * 32'(COLS))
        else $error("refresh read address out of step with the row counter");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> 32'(cursor_reg) < 32'(CELLS))
        else $error("cursor left the screen");

endmodule

FILE: design/char_lcd_shadow_buffer_refresh_unit.sv
// Top level of the character LCD shadow buffer refresh unit.
// Each item runs a microcode program of S steps, one step per cycle except while a write waits
// on a stalled receiver. Refresh takes 1 + ROWS*(COLS+2) steps (37 at 2x16), init 6, a number
// up to 37, two-digit up to 14, place and clear 1, append 2. Init writes from its first step;
// refresh writes first from its row command step, which follows the start step.
// Reset is asynchronous: the cursor goes to cell 0 and every cell reads as a space at once
// through per-cell valid bits, so no clearing pass follows reset.
module char_lcd_shadow_buffer_refresh_unit #(
    parameter int ROWS = clsbr_pkg::DEF_ROWS,
    parameter int COLS = clsbr_pkg::DEF_COLS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic [7:0]         row,
    input  logic [7:0]         col,
    input  logic               use_position,
    input  logic [7:0]         char_code,
    input  logic signed [31:0] number,
    input  logic [7:0]         two_digit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               to_data,
    output logic [7:0]         value,
    output logic               nibble_only,
    output logic               last
);
    import clsbr_pkg::*;

    logic [PCW-1:0] pc;
    cw_t            cw;
    flags_t         flags;
    logic           busy;
    logic           step;
    logic           accept;

    // The block takes a new item whenever no program is running. The output register
    // keeps the last write of the previous run, so a stalled receiver does not block
    // acceptance of the next request.
    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    // The program counter selects a control word from the read-only program table.
    clsbr_ucode_rom u_rom (
        .pc (pc),
        .cw (cw)
    );

    // Step counter with jumps on datapath conditions; it pauses while a write is held.
    clsbr_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (req_type),
        .cw       (cw),
        .flags    (flags),
        .pc       (pc),
        .busy     (busy),
        .step     (step)
    );

    // Screen memory, cursor, decimal digit extraction by repeated subtraction, and the
    // registered output stage.
    clsbr_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .row          (row),
        .col          (col),
        .use_position (use_position),
        .char_code    (char_code),
        .number       (number),
        .two_digit    (two_digit),
        .cw           (cw),
        .step         (step),
        .flags        (flags),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .to_data      (to_data),
        .value        (value),
        .nibble_only  (nibble_only),
        .last         (last)
    );

endmodule
